@@ rtl/core/mvdds_pkg.sv @@
package mvdds_pkg;

  // voice count and gain full scale
  localparam int VOICES          = 4;
  localparam int GAIN_FULL_SCALE = 255;

  // voice index width, at least one bit
  localparam int VIDX_W = (VOICES > 1) ? $clog2(VOICES) : 1;

  localparam int PHASE_W  = 16;
  localparam int SAMPLE_W = 8;
  localparam int GAIN_W   = 8;
  localparam int SUM_W    = 16;
  localparam int DUTY_W   = 14;

  localparam int SINE_DEPTH = 128;
  localparam int LUT_IDX_W  = $clog2(SINE_DEPTH);

  // constant division by reciprocal: q = (x * ceil(2^DIV_SHIFT / d)) >> DIV_SHIFT,
  // exact for 16-bit x and any divisor up to 255
  localparam int DIV_SHIFT   = 24;
  localparam int RECIP_W     = DIV_SHIFT + 1;
  localparam int OPND_W      = 16;
  localparam int PROD_W      = OPND_W + RECIP_W;
  localparam int QUOT_W      = 16;
  localparam int AMP_RECIP   = ((1 << DIV_SHIFT) + GAIN_FULL_SCALE - 1) / GAIN_FULL_SCALE;
  localparam int VOICE_RECIP = ((1 << DIV_SHIFT) + VOICES - 1) / VOICES;

  typedef enum logic [1:0] {
    ACT_TICK = 2'b00,
    ACT_STEP = 2'b01,
    ACT_GAIN = 2'b10
  } act_e;

  typedef enum logic [1:0] {
    WAVE_SINE     = 2'b00,
    WAVE_SQUARE   = 2'b01,
    WAVE_TRIANGLE = 2'b10,
    WAVE_SAW      = 2'b11
  } wave_e;

  typedef enum logic [1:0] {
    MUL_HOLD,
    MUL_GAIN,
    MUL_SCALE,
    MUL_NORM
  } mul_op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADV,
    ST_GAIN,
    ST_SCALE,
    ST_SUM,
    ST_NORM,
    ST_DONE
  } state_e;

  // one period of sine, centered on 128
  localparam logic [SAMPLE_W-1:0] SINE_ROM [SINE_DEPTH] = '{
    8'd128, 8'd134, 8'd140, 8'd146, 8'd152, 8'd158, 8'd165, 8'd170,
    8'd176, 8'd182, 8'd188, 8'd193, 8'd198, 8'd203, 8'd208, 8'd213,
    8'd218, 8'd222, 8'd226, 8'd230, 8'd234, 8'd237, 8'd240, 8'd243,
    8'd245, 8'd248, 8'd250, 8'd251, 8'd253, 8'd254, 8'd254, 8'd255,
    8'd255, 8'd255, 8'd254, 8'd254, 8'd253, 8'd251, 8'd250, 8'd248,
    8'd245, 8'd243, 8'd240, 8'd237, 8'd234, 8'd230, 8'd226, 8'd222,
    8'd218, 8'd213, 8'd208, 8'd203, 8'd198, 8'd193, 8'd188, 8'd182,
    8'd176, 8'd170, 8'd165, 8'd158, 8'd152, 8'd146, 8'd140, 8'd134,
    8'd128, 8'd121, 8'd115, 8'd109, 8'd103, 8'd97,  8'd90,  8'd85,
    8'd79,  8'd73,  8'd67,  8'd62,  8'd57,  8'd52,  8'd47,  8'd42,
    8'd37,  8'd33,  8'd29,  8'd25,  8'd21,  8'd18,  8'd15,  8'd12,
    8'd10,  8'd7,   8'd5,   8'd4,   8'd2,   8'd1,   8'd1,   8'd0,
    8'd0,   8'd0,   8'd1,   8'd1,   8'd2,   8'd4,   8'd5,   8'd7,
    8'd10,  8'd12,  8'd15,  8'd18,  8'd21,  8'd25,  8'd29,  8'd33,
    8'd37,  8'd42,  8'd47,  8'd52,  8'd57,  8'd62,  8'd67,  8'd73,
    8'd79,  8'd85,  8'd90,  8'd97,  8'd103, 8'd109, 8'd115, 8'd121
  };

endpackage

@@ rtl/core/mvdds_wave.sv @@
module mvdds_wave import mvdds_pkg::*; (
  input  wave_e               wave_i,
  input  logic [7:0]          phase_i,
  output logic [SAMPLE_W-1:0] sample_o
);

  always_comb begin
    case (wave_i)
      WAVE_SINE: begin
        sample_o = SINE_ROM[phase_i[7:1]];
      end
      WAVE_SQUARE: begin
        sample_o = phase_i[7] ? 8'd0 : 8'd255;
      end
      WAVE_TRIANGLE: begin
        // rising half 2p, falling half 2*(255-p) = 2*~p
        sample_o = phase_i[7] ? {~phase_i[6:0], 1'b0} : {phase_i[6:0], 1'b0};
      end
      WAVE_SAW: begin
        sample_o = phase_i;
      end
      default: begin
        sample_o = phase_i;
      end
    endcase
  end

endmodule

@@ rtl/core/mvdds_mul_unit.sv @@
module mvdds_mul_unit import mvdds_pkg::*; (
  input  logic                clk_i,
  input  mul_op_e             op_i,
  input  logic [SAMPLE_W-1:0] sample_i,
  input  logic [GAIN_W-1:0]   gain_i,
  input  logic [SUM_W-1:0]    sum_i,
  output logic [QUOT_W-1:0]   quot_o
);

  logic [PROD_W-1:0]  prod_q, prod_d;
  logic [OPND_W-1:0]  opa;
  logic [RECIP_W-1:0] opb;

  // operand select for the one shared multiplier
  always_comb begin
    case (op_i)
      MUL_GAIN: begin
        opa = OPND_W'(sample_i);
        opb = RECIP_W'(gain_i);
      end
      MUL_SCALE: begin
        opa = prod_q[OPND_W-1:0];
        opb = RECIP_W'(AMP_RECIP);
      end
      MUL_NORM: begin
        opa = OPND_W'(sum_i);
        opb = RECIP_W'(VOICE_RECIP);
      end
      default: begin
        opa = '0;
        opb = '0;
      end
    endcase
  end

  always_comb begin
    prod_d = (op_i == MUL_HOLD) ? prod_q : (PROD_W'(opa) * PROD_W'(opb));
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
  end

  assign quot_o = prod_q[DIV_SHIFT +: QUOT_W];

endmodule

@@ rtl/core/multi_voice_dds_mixer.sv @@
// multi-voice dds mixer
// input channel (in_valid_i / in_ready_o): action_i, voice_i, value_i.
//   set phase step / set gain: written in the cycle of the transfer, no result,
//   the block is ready again at the next edge.
//   sample tick: the block drops in_ready_o and walks the voices one at a time
//   through one shared datapath: phase advance + waveform, gain multiply,
//   divide by max amplitude, accumulate, in states ADV, GAIN, SCALE and SUM
//   for each voice; then NORM divides by the voice count and DONE loads the
//   output register.
// output channel (out_valid_o / out_ready_i): one registered result per tick.
//   while a result waits, new set actions are still taken; a tick that
//   finishes before the older result is taken holds in its last step until
//   the receiver takes it.
// configuration: cfg_we_i writes cfg_wdata_i into the waveform select
//   (sine, square, triangle, sawtooth), no wait state.
// reset: accumulators and steps go to zero, every gain to one, sine selected,
//   no result pending.
module multi_voice_dds_mixer import mvdds_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [1:0]          action_i,
  input  logic [1:0]          voice_i,
  input  logic [15:0]         value_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [DUTY_W-1:0]   duty_o
);

  localparam logic [VIDX_W-1:0] LAST_VOICE = VIDX_W'(VOICES - 1);

  state_e state_q, state_d;
  wave_e  wave_q;

  logic [PHASE_W-1:0] acc_q  [VOICES];
  logic [PHASE_W-1:0] step_q [VOICES];
  logic [GAIN_W-1:0]  gain_q [VOICES];

  logic [VIDX_W-1:0]   voice_cnt_q;
  logic [SUM_W-1:0]    sum_q;
  logic [SAMPLE_W-1:0] sample_q;
  logic                out_valid_q;
  logic [DUTY_W-1:0]   duty_q;

  logic [PHASE_W-1:0]  acc_next;
  logic [SAMPLE_W-1:0] wave_sample;
  logic [QUOT_W-1:0]   quot;
  mul_op_e             mul_op;
  logic                in_xfer;
  logic                out_free;
  act_e                act;

  assign act      = act_e'(action_i);
  assign in_xfer  = in_valid_i && in_ready_o;
  assign out_free = !out_valid_q || out_ready_i;

  // phase advance for the voice being visited
  assign acc_next = acc_q[voice_cnt_q] + step_q[voice_cnt_q];

  mvdds_wave u_wave (
    .wave_i   (wave_q),
    .phase_i  (acc_next[PHASE_W-1 -: 8]),
    .sample_o (wave_sample)
  );

  mvdds_mul_unit u_mul (
    .clk_i    (clk_i),
    .op_i     (mul_op),
    .sample_i (sample_q),
    .gain_i   (gain_q[voice_cnt_q]),
    .sum_i    (sum_q),
    .quot_o   (quot)
  );

  // sequencer: next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_xfer && act == ACT_TICK) begin
          state_d = ST_ADV;
        end
      end
      ST_ADV:   state_d = ST_GAIN;
      ST_GAIN:  state_d = ST_SCALE;
      ST_SCALE: state_d = ST_SUM;
      ST_SUM: begin
        state_d = (voice_cnt_q == LAST_VOICE) ? ST_NORM : ST_ADV;
      end
      ST_NORM:  state_d = ST_DONE;
      ST_DONE: begin
        // hold until the output register can take the new duty
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default:  state_d = ST_IDLE;
    endcase
  end

  // sequencer: outputs
  always_comb begin
    in_ready_o = 1'b0;
    mul_op     = MUL_HOLD;
    case (state_q)
      ST_IDLE:  in_ready_o = 1'b1;
      ST_GAIN:  mul_op = MUL_GAIN;
      ST_SCALE: mul_op = MUL_SCALE;
      ST_NORM:  mul_op = MUL_NORM;
      default: begin
        in_ready_o = 1'b0;
        mul_op     = MUL_HOLD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // waveform select register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wave_q <= WAVE_SINE;
    end else if (cfg_we_i) begin
      wave_q <= wave_e'(cfg_wdata_i);
    end
  end

  // per-voice state: set actions and phase advance
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < VOICES; i++) begin
        acc_q[i]  <= '0;
        step_q[i] <= '0;
        gain_q[i] <= GAIN_W'(1);
      end
    end else begin
      if (state_q == ST_ADV) begin
        acc_q[voice_cnt_q] <= acc_next;
      end
      if (in_xfer) begin
        // voices the 2-bit field cannot name are never matched
        for (int i = 0; i < VOICES; i++) begin
          if (int'(voice_i) == i) begin
            if (act == ACT_STEP) begin
              step_q[i] <= value_i;
            end
            if (act == ACT_GAIN) begin
              gain_q[i] <= value_i[GAIN_W-1:0];
            end
          end
        end
      end
    end
  end

  // voice walk and mix accumulator
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      voice_cnt_q <= '0;
      sum_q       <= '0;
    end else begin
      if (in_xfer && act == ACT_TICK) begin
        voice_cnt_q <= '0;
        sum_q       <= '0;
      end else if (state_q == ST_SUM) begin
        sum_q <= sum_q + quot;
        if (voice_cnt_q != LAST_VOICE) begin
          voice_cnt_q <= voice_cnt_q + VIDX_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_ADV) begin
      sample_q <= wave_sample;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == ST_DONE && out_free) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_DONE && out_free) begin
      duty_q <= quot[DUTY_W-1:0];
    end
  end

  assign out_valid_o = out_valid_q;
  assign duty_o      = duty_q;

`ifndef SYNTHESIS
  // a tick starts the walk at the first voice with an empty mix
  a_tick_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer && act == ACT_TICK |=> state_q == ST_ADV && voice_cnt_q == '0 && sum_q == '0)
    else $error("tick did not start voice walk");

  // set actions never occupy the sequencer
  a_set_stays_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer && act != ACT_TICK |=> state_q == ST_IDLE)
    else $error("set action left idle");

  // the last voice leads to the normalize step
  a_last_voice_norm: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_SUM && voice_cnt_q == LAST_VOICE |=> state_q == ST_NORM)
    else $error("voice walk did not end at last voice");

  // a finished tick always leaves a result pending
  a_done_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DONE && out_free |=> out_valid_q && state_q == ST_IDLE)
    else $error("finished tick lost its result");
`endif

endmodule

@@ bench/tb_multi_voice_dds_mixer.sv @@
`timescale 1ns / 100ps

// self-checking bench for the four-voice dds mixer
module tb_multi_voice_dds_mixer import mvdds_pkg::*; ();

  // action code outside the package enum, must be ignored by the block
  localparam logic [1:0] ACT_UNUSED = 2'b11;

  localparam int PHASES      = 8;
  localparam int PHASE_ITEMS = 175;
  localparam int HOLD_CYCLES = 400;
  // tick walk plus the idle cycle
  localparam int TICK_CYCLES = 4 * VOICES + 3;
  // long receiver hold, a full tick and sender gaps, taken many times over
  localparam int QUIET_LIMIT = 5000;

  typedef enum logic [1:0] {
    IDLE_NONE,
    IDLE_SEND,
    IDLE_RECV,
    IDLE_BOTH
  } idle_mode_e;

  typedef struct packed {
    logic [1:0]        action;
    logic [1:0]        voice;
    logic [15:0]       value;
    logic              typed;
    logic [DUTY_W-1:0] duty;
  } stim_row_t;

  // own copy of the one-period sine table
  localparam logic [7:0] SINE_TBL [128] = '{
    8'd128, 8'd134, 8'd140, 8'd146, 8'd152, 8'd158, 8'd165, 8'd170,
    8'd176, 8'd182, 8'd188, 8'd193, 8'd198, 8'd203, 8'd208, 8'd213,
    8'd218, 8'd222, 8'd226, 8'd230, 8'd234, 8'd237, 8'd240, 8'd243,
    8'd245, 8'd248, 8'd250, 8'd251, 8'd253, 8'd254, 8'd254, 8'd255,
    8'd255, 8'd255, 8'd254, 8'd254, 8'd253, 8'd251, 8'd250, 8'd248,
    8'd245, 8'd243, 8'd240, 8'd237, 8'd234, 8'd230, 8'd226, 8'd222,
    8'd218, 8'd213, 8'd208, 8'd203, 8'd198, 8'd193, 8'd188, 8'd182,
    8'd176, 8'd170, 8'd165, 8'd158, 8'd152, 8'd146, 8'd140, 8'd134,
    8'd128, 8'd121, 8'd115, 8'd109, 8'd103, 8'd97,  8'd90,  8'd85,
    8'd79,  8'd73,  8'd67,  8'd62,  8'd57,  8'd52,  8'd47,  8'd42,
    8'd37,  8'd33,  8'd29,  8'd25,  8'd21,  8'd18,  8'd15,  8'd12,
    8'd10,  8'd7,   8'd5,   8'd4,   8'd2,   8'd1,   8'd1,   8'd0,
    8'd0,   8'd0,   8'd1,   8'd1,   8'd2,   8'd4,   8'd5,   8'd7,
    8'd10,  8'd12,  8'd15,  8'd18,  8'd21,  8'd25,  8'd29,  8'd33,
    8'd37,  8'd42,  8'd47,  8'd52,  8'd57,  8'd62,  8'd67,  8'd73,
    8'd79,  8'd85,  8'd90,  8'd97,  8'd103, 8'd109, 8'd115, 8'd121
  };

  // directed opening, run right after reset with sine selected
  localparam int DIR_ROWS = 22;
  localparam stim_row_t DIR_TBL [DIR_ROWS] = '{
    // all phases zero, sine at 128, unit gain truncates to zero
    '{ACT_TICK,   2'd0, 16'h0000, 1'b1, 14'd0},
    // unused action code, no result and no state change
    '{ACT_UNUSED, 2'd3, 16'hFFFF, 1'b0, 14'd0},
    // full gain, upper value bits must be dropped
    '{ACT_GAIN,   2'd0, 16'hFFFF, 1'b0, 14'd0},
    '{ACT_GAIN,   2'd1, 16'h00FF, 1'b0, 14'd0},
    '{ACT_GAIN,   2'd2, 16'h55FF, 1'b0, 14'd0},
    '{ACT_GAIN,   2'd3, 16'hAAFF, 1'b0, 14'd0},
    // phases still zero, four voices at 128 average to 128
    '{ACT_TICK,   2'd0, 16'h0000, 1'b1, 14'd128},
    '{ACT_STEP,   2'd0, 16'hFFFF, 1'b0, 14'd0},
    '{ACT_STEP,   2'd1, 16'h8000, 1'b0, 14'd0},
    '{ACT_STEP,   2'd2, 16'h0001, 1'b0, 14'd0},
    '{ACT_STEP,   2'd3, 16'h7FFF, 1'b0, 14'd0},
    '{ACT_TICK,   2'd3, 16'hFFFF, 1'b0, 14'd0},
    '{ACT_TICK,   2'd0, 16'h0000, 1'b0, 14'd0},
    '{ACT_TICK,   2'd1, 16'h1234, 1'b0, 14'd0},
    // zero gain, low byte zero with upper bits set
    '{ACT_GAIN,   2'd2, 16'h0000, 1'b0, 14'd0},
    '{ACT_GAIN,   2'd3, 16'hFF00, 1'b0, 14'd0},
    '{ACT_TICK,   2'd2, 16'h0000, 1'b0, 14'd0},
    '{ACT_UNUSED, 2'd0, 16'h0000, 1'b0, 14'd0},
    '{ACT_STEP,   2'd1, 16'h0000, 1'b0, 14'd0},
    '{ACT_GAIN,   2'd1, 16'h0080, 1'b0, 14'd0},
    '{ACT_TICK,   2'd0, 16'h0000, 1'b0, 14'd0},
    '{ACT_TICK,   2'd0, 16'h0000, 1'b0, 14'd0}
  };

  // phase plan: waveform and idling per phase
  localparam wave_e PHASE_WAVE [PHASES] = '{
    WAVE_SAW, WAVE_SQUARE, WAVE_TRIANGLE, WAVE_SINE,
    WAVE_SAW, WAVE_TRIANGLE, WAVE_SQUARE, WAVE_SINE
  };
  localparam idle_mode_e PHASE_MODE [PHASES] = '{
    IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH,
    IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH
  };
  // phase in which the receiver holds off for a long stretch
  localparam int HOLD_PHASE = 2;

  logic              clk_i       = 1'b0;
  logic              rst_ni      = 1'b0;
  logic              cfg_we_i    = 1'b0;
  logic [1:0]        cfg_wdata_i = 2'b00;
  logic              in_valid_i  = 1'b0;
  logic              in_ready_o;
  logic [1:0]        action_i    = 2'b00;
  logic [1:0]        voice_i     = 2'b00;
  logic [15:0]       value_i     = 16'h0000;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  logic [DUTY_W-1:0] duty_o;

  // predictor state
  logic [15:0] acc_q  [VOICES];
  logic [15:0] step_q [VOICES];
  logic [7:0]  gain_q [VOICES];
  wave_e       wave_sel;

  logic [DUTY_W-1:0] duty_expect_q [$];

  idle_mode_e idle_mode = IDLE_NONE;
  int         hold_asks = 0;
  int         hold_done = 0;
  int         hold_left = 0;
  int         quiet_cycles = 0;
  int         mismatches = 0;
  int         results_seen = 0;
  int         items_sent = 0;
  int         ticks_sent = 0;

  multi_voice_dds_mixer dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .action_i    (action_i),
    .voice_i     (voice_i),
    .value_i     (value_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .duty_o      (duty_o)
  );

  always #5 clk_i = ~clk_i;

  function automatic int send_idle_pct();
    case (idle_mode)
      IDLE_SEND: return 67;
      IDLE_BOTH: return 30;
      default:   return 0;
    endcase
  endfunction

  function automatic int recv_stall_pct();
    case (idle_mode)
      IDLE_RECV: return 67;
      IDLE_BOTH: return 30;
      default:   return 0;
    endcase
  endfunction

  // one tick: advance every voice, shape, scale, sum with 16-bit wrap, average
  function automatic logic [DUTY_W-1:0] mix_tick();
    logic [15:0] total;
    logic [7:0]  p;
    int unsigned level;
    int unsigned scaled;
    total = '0;
    for (int k = 0; k < VOICES; k++) begin
      acc_q[k] = acc_q[k] + step_q[k];
      p = acc_q[k][15:8];
      case (wave_sel)
        WAVE_SINE:     level = SINE_TBL[p[7:1]];
        WAVE_SQUARE:   level = p[7] ? 0 : 255;
        WAVE_TRIANGLE: level = p[7] ? 2 * (255 - int'(p)) : 2 * int'(p);
        default:       level = p;
      endcase
      scaled = (level * gain_q[k]) / GAIN_FULL_SCALE;
      total = total + scaled[15:0];
    end
    return DUTY_W'(total / VOICES);
  endfunction

  // offer one item from a falling edge, track it into the predictor once transferred
  task automatic offer_item(input logic [1:0] act, input logic [1:0] vc,
                            input logic [15:0] val, input logic typed,
                            input logic [DUTY_W-1:0] typed_duty);
    logic [DUTY_W-1:0] duty_calc;
    while ($urandom_range(0, 99) < send_idle_pct()) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    action_i   <= act;
    voice_i    <= vc;
    value_i    <= val;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    items_sent++;
    case (act)
      ACT_STEP: if (int'(vc) < VOICES) step_q[vc] = val;
      ACT_GAIN: if (int'(vc) < VOICES) gain_q[vc] = val[7:0];
      ACT_TICK: begin
        ticks_sent++;
        duty_calc = mix_tick();
        duty_expect_q.push_back(typed ? typed_duty : duty_calc);
      end
      default: ;
    endcase
    @(negedge clk_i);
  endtask

  // drain all results, then give a late item the full tick latency
  task automatic settle();
    while (duty_expect_q.size() != 0) @(negedge clk_i);
    repeat (TICK_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_wave(input wave_e w);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= w;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    wave_sel = w;
  endtask

  // receiver: random stalls, plus a long counted hold when asked
  always @(negedge clk_i) begin
    if (hold_left != 0) begin
      hold_left = hold_left - 1;
      out_ready_i <= 1'b0;
    end else if (hold_asks != hold_done) begin
      hold_done = hold_done + 1;
      hold_left = HOLD_CYCLES;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(0, 99) >= recv_stall_pct());
    end
  end

  // result check against the oldest expectation
  always @(posedge clk_i) begin
    if (out_valid_o && out_ready_i) begin
      results_seen++;
      if (duty_expect_q.size() == 0) begin
        $error("duty %0d with no expectation pending", duty_o);
        mismatches++;
      end else if (duty_o !== duty_expect_q[0]) begin
        $error("duty mismatch: expected %0d, actual %0d", duty_expect_q[0], duty_o);
        mismatches++;
        void'(duty_expect_q.pop_front());
      end else begin
        void'(duty_expect_q.pop_front());
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i))
      quiet_cycles = 0;
    else
      quiet_cycles = quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("timeout after %0d quiet cycles", quiet_cycles);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    logic [1:0]  act;
    logic [1:0]  vc;
    logic [15:0] val;
    int          n;
    int          r;

    for (int k = 0; k < VOICES; k++) begin
      acc_q[k]  = '0;
      step_q[k] = '0;
      gain_q[k] = 8'd1;
    end
    wave_sel = WAVE_SINE;

    // reset held from the start, released on a falling edge
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed rows, no idling
    for (int i = 0; i < DIR_ROWS; i++)
      offer_item(DIR_TBL[i].action, DIR_TBL[i].voice, DIR_TBL[i].value,
                 DIR_TBL[i].typed, DIR_TBL[i].duty);
    in_valid_i <= 1'b0;

    for (int ph = 0; ph < PHASES; ph++) begin
      // waveform only changes with the block drained
      settle();
      write_wave(PHASE_WAVE[ph]);
      idle_mode = PHASE_MODE[ph];
      if (ph == HOLD_PHASE) hold_asks++;
      n = 0;
      while (n < PHASE_ITEMS) begin
        r = $urandom_range(0, 99);
        if (r < 50)      act = ACT_TICK;
        else if (r < 72) act = ACT_STEP;
        else if (r < 95) act = ACT_GAIN;
        else             act = ACT_UNUSED;
        vc = 2'($urandom_range(0, 3));
        // mix of extremes, slow steps and full-range values
        case ($urandom_range(0, 5))
          0:       val = 16'hFFFF;
          1:       val = 16'h0000;
          2:       val = 16'($urandom_range(0, 1023));
          default: val = 16'($urandom);
        endcase
        offer_item(act, vc, val, 1'b0, '0);
        if (act != ACT_UNUSED) n++;
      end
      in_valid_i <= 1'b0;
    end

    settle();
    $display("covered %0d items with %0d ticks over %0d waveform phases",
             items_sent, ticks_sent, PHASES);
    $display("checked %0d duty results, %0d mismatches", results_seen, mismatches);
    if (mismatches == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
